// ===== src/frame_dirty_rect_finder_defines.svh =====
// assertion macros for the dirty rectangle finder
`ifndef FRAME_DIRTY_RECT_FINDER_DEFINES_SVH
`define FRAME_DIRTY_RECT_FINDER_DEFINES_SVH

// same-cycle implication
`define FDRF_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("fdrf assertion failed");

// next-cycle implication
`define FDRF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("fdrf assertion failed");

`endif

// ===== src/fdrf_pkg.sv =====
// package for the dirty rectangle finder: sizes, payload types, register indexes
package fdrf_pkg;

    localparam int MAX_ROW_WORDS = 512;
    localparam int MAX_ROWS      = 512;
    localparam int POS_W         = 9;
    localparam int SIZE_W        = 10;
    localparam int WORD_W        = 32;
    localparam int DEPTH         = MAX_ROWS * MAX_ROW_WORDS;
    localparam int ADDR_W        = $clog2(DEPTH);
    localparam int TOP_ROW_WORDS = (MAX_ROW_WORDS < 512) ? MAX_ROW_WORDS : 512;
    localparam int TOP_ROWS      = (MAX_ROWS < 512) ? MAX_ROWS : 512;

    localparam logic CFG_ROW_WORDS  = 1'b0;
    localparam logic CFG_FRAME_ROWS = 1'b1;

    localparam logic CMD_WORD       = 1'b0;
    localparam logic CMD_INVALIDATE = 1'b1;

    typedef struct packed {
        logic              command;
        logic [WORD_W-1:0] screen_word;
    } t_in_word;

    typedef struct packed {
        logic              changed;
        logic [POS_W-1:0]  top_row;
        logic [POS_W-1:0]  left_col;
        logic [SIZE_W-1:0] bottom_row;
        logic [SIZE_W-1:0] right_col;
    } t_out_word;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] top);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > top) begin
            r = top;
        end
        return r;
    endfunction

endpackage

// ===== src/frame_dirty_rect_finder.sv =====
// dirty rectangle finder: shadow compare of streamed frame words and bounding box report
//
// input channel (i_valid / o_ready, i_data): one word per item, either a frame word
// in raster order or an invalidate command. config channel (i_cfg_valid / o_cfg_ready,
// i_cfg_index, i_cfg_data) sets words per row (index 0) and rows per frame (index 1);
// write only while the block is idle. output channel (o_valid / i_ready, o_data):
// one word after the last frame word of each frame, with the changed flag and the
// box (bottom and right exclusive).
// throughput is one item per cycle while o_ready is high: the shadow ram takes one read
// at acceptance and one write-back from the compare stage, with the previous word
// forwarded when both hit the same address. the compare stage feeds the output register.
// results wait in the output register backed by one spare register; while both are
// full, a frame-end word holds in the compare stage and o_ready drops. o_ready comes
// from registers only, so i_ready never reaches it in the same cycle.
// reset (synchronous, active low) sets both sizes to 512, clears position and box and
// marks the shadow invalid, so the first frame reports the full frame; the shadow ram
// itself is not cleared.
module frame_dirty_rect_finder
    import fdrf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_in_word          i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output t_out_word         o_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [SIZE_W-1:0] i_cfg_data
);

`include "frame_dirty_rect_finder_defines.svh"

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    logic [SIZE_W-1:0] r_rw;
    logic [SIZE_W-1:0] r_fr;
    logic [POS_W-1:0]  r_col;
    logic [POS_W-1:0]  r_row;

    logic              r_b_valid;
    logic              r_b_cmd;
    logic              r_b_fe;
    logic [WORD_W-1:0] r_b_word;
    logic [ADDR_W-1:0] r_b_addr;
    logic [POS_W-1:0]  r_b_row;
    logic [POS_W-1:0]  r_b_col;
    logic              r_b_fwd;
    logic [WORD_W-1:0] r_b_fwd_word;

    logic              r_invalid;
    logic              r_any;
    logic [POS_W-1:0]  r_min_row;
    logic [POS_W-1:0]  r_max_row;
    logic [POS_W-1:0]  r_min_col;
    logic [POS_W-1:0]  r_max_col;

    logic              r_out_valid;
    t_out_word         r_out;
    logic              r_skid_valid;
    t_out_word         r_skid;

    logic              n_any;
    logic [POS_W-1:0]  n_min_row;
    logic [POS_W-1:0]  n_max_row;
    logic [POS_W-1:0]  n_min_col;
    logic [POS_W-1:0]  n_max_col;
    t_out_word         n_out;

    logic              w_acc;
    logic              w_b_stall;
    logic              w_b_go;
    logic              w_take;
    logic              w_spill;
    logic              w_row_end;
    logic              w_row_last;
    logic [ADDR_W-1:0] w_addr;
    logic [WORD_W-1:0] w_old;
    logic              w_diff;
    logic              w_quiet;
    logic              w_box_zero;

    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;

    assign w_b_stall = r_b_valid && r_b_fe && r_skid_valid;
    assign w_b_go    = r_b_valid && !w_b_stall;
    assign o_ready   = !w_b_stall;
    assign w_acc     = i_valid && o_ready;
    assign w_take    = w_b_go && (r_b_cmd == CMD_WORD) && r_b_fe;
    assign w_spill   = w_take && r_out_valid && !i_ready;

    assign w_addr     = ADDR_W'(r_row) * ADDR_W'(MAX_ROW_WORDS) + ADDR_W'(r_col);
    assign w_row_end  = ({1'b0, r_col} + SIZE_W'(1)) >= r_rw;
    assign w_row_last = ({1'b0, r_row} + SIZE_W'(1)) >= r_fr;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rw <= SIZE_W'(512);
            r_fr <= SIZE_W'(512);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROW_WORDS:  r_rw <= clamp_size(i_cfg_data, SIZE_W'(TOP_ROW_WORDS));
                CFG_FRAME_ROWS: r_fr <= clamp_size(i_cfg_data, SIZE_W'(TOP_ROWS));
                default: ;
            endcase
        end
    end

    // shadow ram
    always_ff @(posedge i_clk) begin
        if (w_b_go && (r_b_cmd == CMD_WORD)) begin
            r_mem[r_b_addr] <= r_b_word;
        end
        if (w_acc && (i_data.command == CMD_WORD)) begin
            r_rdata <= r_mem[w_addr];
        end
    end

    // position and compare stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_b_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_b_valid <= 1'b1;
                if (i_data.command == CMD_WORD) begin
                    if (w_row_end) begin
                        r_col <= '0;
                        r_row <= w_row_last ? '0 : r_row + POS_W'(1);
                    end else begin
                        r_col <= r_col + POS_W'(1);
                    end
                end
            end else if (w_b_go) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    // compare stage payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_b_cmd      <= i_data.command;
            r_b_fe       <= (i_data.command == CMD_WORD) && w_row_end && w_row_last;
            r_b_word     <= i_data.screen_word;
            r_b_addr     <= w_addr;
            r_b_row      <= r_row;
            r_b_col      <= r_col;
            r_b_fwd      <= r_b_valid && (r_b_cmd == CMD_WORD) && (r_b_addr == w_addr);
            r_b_fwd_word <= r_b_word;
        end
    end

    assign w_old  = r_b_fwd ? r_b_fwd_word : r_rdata;
    assign w_diff = w_old != r_b_word;

    always_comb begin
        n_any     = r_any;
        n_min_row = r_min_row;
        n_max_row = r_max_row;
        n_min_col = r_min_col;
        n_max_col = r_max_col;
        if (w_diff) begin
            n_any = 1'b1;
            if (r_b_row < r_min_row) n_min_row = r_b_row;
            if (r_b_row > r_max_row) n_max_row = r_b_row;
            if (r_b_col < r_min_col) n_min_col = r_b_col;
            if (r_b_col > r_max_col) n_max_col = r_b_col;
        end
        n_out = '0;
        if (r_invalid) begin
            n_out.changed    = 1'b1;
            n_out.bottom_row = r_fr;
            n_out.right_col  = r_rw;
        end else if (n_any) begin
            n_out.changed    = 1'b1;
            n_out.top_row    = n_min_row;
            n_out.left_col   = n_min_col;
            n_out.bottom_row = {1'b0, n_max_row} + SIZE_W'(1);
            n_out.right_col  = {1'b0, n_max_col} + SIZE_W'(1);
        end
    end

    // box tracking and invalid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invalid <= 1'b1;
            r_any     <= 1'b0;
            r_min_row <= '1;
            r_max_row <= '0;
            r_min_col <= '1;
            r_max_col <= '0;
        end else if (w_b_go) begin
            if (r_b_cmd == CMD_INVALIDATE) begin
                r_invalid <= 1'b1;
            end else if (r_b_fe) begin
                r_invalid <= 1'b0;
                r_any     <= 1'b0;
                r_min_row <= '1;
                r_max_row <= '0;
                r_min_col <= '1;
                r_max_col <= '0;
            end else begin
                r_any     <= n_any;
                r_min_row <= n_min_row;
                r_max_row <= n_max_row;
                r_min_col <= n_min_col;
                r_max_col <= n_max_col;
            end
        end
    end

    // output register and spare register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_ready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_spill) begin
            r_skid_valid <= 1'b1;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid && i_ready) begin
            r_out <= r_skid;
        end else if (w_take && !w_spill) begin
            r_out <= n_out;
        end
        if (w_spill) begin
            r_skid <= n_out;
        end
    end

    assign w_quiet    = r_out_valid && !r_out.changed;
    assign w_box_zero = (r_out.bottom_row == '0) && (r_out.right_col == '0);

    `FDRF_ASSERT_NEXT(a_b_hold, i_clk, i_rst_n, w_b_stall, r_b_valid && $stable(r_b_addr))
    `FDRF_ASSERT_NEXT(a_take_valid, i_clk, i_rst_n, w_take, r_out_valid)
    `FDRF_ASSERT_NEXT(a_report_clears, i_clk, i_rst_n, w_take, !r_invalid && !r_any)
    `FDRF_ASSERT_NOW(a_quiet_box, i_clk, i_rst_n, w_quiet, w_box_zero)
    `FDRF_ASSERT_NOW(a_skid_head, i_clk, i_rst_n, r_skid_valid, r_out_valid)

endmodule
